// ===== src/vaq_pkg.sv =====
// Shared constants, operation codes and width helpers for the vector ALU.
package vaq_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam int OP_W     = 4;
    localparam int MASK_W   = 4;
    localparam int CLS_W    = 2;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_SCALE  = 4'd2;
    localparam logic [OP_W-1:0] OP_INV    = 4'd3;
    localparam logic [OP_W-1:0] OP_DOT    = 4'd4;
    localparam logic [OP_W-1:0] OP_CROSS  = 4'd5;
    localparam logic [OP_W-1:0] OP_LERP   = 4'd6;
    localparam logic [OP_W-1:0] OP_SQLEN  = 4'd7;
    localparam logic [OP_W-1:0] OP_LEN    = 4'd8;
    localparam logic [OP_W-1:0] OP_SQDIST = 4'd9;
    localparam logic [OP_W-1:0] OP_DIST   = 4'd10;
    localparam logic [OP_W-1:0] OP_NORM   = 4'd11;
    localparam logic [OP_W-1:0] OP_HOMO   = 4'd12;

    // item classes set by the front end
    localparam logic [CLS_W-1:0] CLS_PIPE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_DZ   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ITER = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SAT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DZ  = 2'd2;

    // queued item layout: op, class, mask, then scalar, a xyzw, b xyzw
    localparam int OP_LSB      = 0;
    localparam int CLS_LSB     = 4;
    localparam int MASK_LSB    = 6;
    localparam int DATA_LSB    = 10;
    localparam int ITEM_WORDS  = 9;

    function automatic int item_w(input int w);
        return DATA_LSB + ITEM_WORDS * w;
    endfunction

    // multiplier operand width: holds a-b and 1.0-scalar
    function automatic int oper_w(input int w, input int f);
        return (w + 1 > f + 2) ? w + 1 : f + 2;
    endfunction

    // width of pre-saturation values: sums of products and quotients
    function automatic int wide_w(input int w, input int f);
        int s;
        int q;
        s = 2 * oper_w(w, f) + 2;
        q = w + f + 2;
        return (s > q) ? s : q;
    endfunction

endpackage

// ===== src/vaq_front.sv =====
// Front end: accepts commands, classifies them and hands them to the queue.
module vaq_front
    import vaq_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [OP_W-1:0]                     action,
    input  logic signed [COMP_WIDTH-1:0]        ax,
    input  logic signed [COMP_WIDTH-1:0]        ay,
    input  logic signed [COMP_WIDTH-1:0]        az,
    input  logic signed [COMP_WIDTH-1:0]        aw,
    input  logic signed [COMP_WIDTH-1:0]        bx,
    input  logic signed [COMP_WIDTH-1:0]        by,
    input  logic signed [COMP_WIDTH-1:0]        bz,
    input  logic signed [COMP_WIDTH-1:0]        bw,
    input  logic signed [COMP_WIDTH-1:0]        scalar_in,
    input  logic [MASK_W-1:0]                   comp_mask,
    output logic                                item_valid,
    output logic [item_w(COMP_WIDTH)-1:0]       item,
    input  logic                                item_ready
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [item_w(COMP_WIDTH)-1:0] item_reg;
    logic [CLS_W-1:0]              cls;
    logic                          accept;
    logic                          push;

    // classify: zero divisors resolve here, root and divide ops go iterative
    always_comb
    begin
        unique case (action) inside
            OP_LEN, OP_DIST:
            begin
                cls = CLS_ITER;
            end
            OP_NORM:
            begin
                cls = (ax == '0 && ay == '0 && az == '0) ? CLS_DZ : CLS_ITER;
            end
            OP_HOMO:
            begin
                cls = (aw == '0) ? CLS_DZ : CLS_ITER;
            end
            default:
            begin
                cls = CLS_PIPE;
            end
        endcase
    end

    assign push   = valid_reg && item_ready;
    assign busy   = valid_reg && !item_ready;
    assign accept = start && !busy;

    // hold one beat until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= {bw, bz, by, bx, aw, az, ay, ax, scalar_in, comp_mask, cls, action};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/vaq_fifo.sv =====
// Short register queue between the front end and the execution back end.
module vaq_fifo
    import vaq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             wr_ready,
    input  logic             rd_en,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    // advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/vaq_iter.sv =====
// Iterative unit: bit-serial square root and three parallel restoring dividers.
module vaq_iter
    import vaq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                start,
    input  logic [OP_W-1:0]                                     op,
    input  logic signed [COMP_WIDTH-1:0]                        a_in [4],
    input  logic signed [wide_w(COMP_WIDTH, FRAC_BITS)-1:0]     sum,
    output logic                                                res_valid,
    output logic signed [wide_w(COMP_WIDTH, FRAC_BITS)-1:0]     res [5]
);

    localparam int W    = COMP_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int WV   = wide_w(COMP_WIDTH, FRAC_BITS);
    localparam int N    = W + 1;
    localparam int RADW = 2 * N;
    localparam int NW   = W + F;
    localparam int CW   = $clog2(NW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    localparam logic signed [WV-1:0] ONE_V = WV'(1) << F;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [OP_W-1:0]       op_reg;
    logic [RADW-1:0]       rad_reg;
    logic [RADW-1:0]       rad_next;
    logic [N-1:0]          root_reg;
    logic [N-1:0]          root_next;
    logic [N:0]            rrem_reg;
    logic [N:0]            rrem_next;
    logic [N-1:0]          dvs_reg;
    logic [N-1:0]          dvs_next;
    logic [NW-1:0]         num_reg [3];
    logic [NW-1:0]         num_next [3];
    logic [N-1:0]          drem_reg [3];
    logic [N-1:0]          drem_next [3];
    logic                  neg_reg [3];
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic signed [WV-1:0]  res_reg [5];
    logic signed [WV-1:0]  res_next [5];
    logic [N+2:0]          rem_sh;
    logic [N+2:0]          trial;
    logic                  root_ge;
    logic [N:0]            dsh [3];
    logic                  dge [3];
    logic [W-1:0]          mag_a [3];
    logic [W-1:0]          mag_w;

    // operand magnitudes for the dividers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a[i] = a_in[i][W-1] ? W'(-a_in[i]) : W'(a_in[i]);
        end
        mag_w = a_in[3][W-1] ? W'(-a_in[3]) : W'(a_in[3]);
    end

    // one root digit: shift in two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh  = {rrem_reg, rad_reg[RADW-1 -: 2]};
        trial   = (N+3)'({root_reg, 2'b01});
        root_ge = (rem_sh >= trial);
    end

    // one quotient bit per divider
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsh[i] = {drem_reg[i], num_reg[i][NW-1]};
            dge[i] = (dsh[i] >= {1'b0, dvs_reg});
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rrem_next      = rrem_reg;
        dvs_next       = dvs_reg;
        res_valid_next = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            res_next[i] = res_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            num_next[i]  = num_reg[i];
            drem_next[i] = drem_reg[i];
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = '0;
                    rad_next  = sum[RADW-1:0];
                    root_next = '0;
                    rrem_next = '0;
                    dvs_next  = N'(mag_w);
                    for (int i = 0; i < 3; i++)
                    begin
                        num_next[i]  = {mag_a[i], {F{1'b0}}};
                        drem_next[i] = '0;
                    end
                    state_next = (op == OP_HOMO) ? S_DIV : S_ROOT;
                end
            end
            S_ROOT:
            begin
                rrem_next = root_ge ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
                root_next = {root_reg[N-2:0], root_ge};
                rad_next  = {rad_reg[RADW-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(N - 1))
                begin
                    cnt_next = '0;
                    if (op_reg == OP_NORM)
                    begin
                        dvs_next   = root_next;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        res_next[0]    = '0;
                        res_next[1]    = '0;
                        res_next[2]    = '0;
                        res_next[3]    = '0;
                        res_next[4]    = WV'(root_next);
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_next[i] = dge[i] ? N'(dsh[i] - {1'b0, dvs_reg}) : dsh[i][N-1:0];
                    num_next[i]  = {num_reg[i][NW-2:0], dge[i]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = neg_reg[i] ? -WV'(num_next[i]) : WV'(num_next[i]);
                    end
                    res_next[3]    = (op_reg == OP_HOMO) ? ONE_V : '0;
                    res_next[4]    = '0;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rrem_reg <= rrem_next;
        dvs_reg  <= dvs_next;
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i]  <= num_next[i];
            drem_reg[i] <= drem_next[i];
        end
        for (int i = 0; i < 5; i++)
        begin
            res_reg[i] <= res_next[i];
        end
        if (state_reg == S_IDLE && start)
        begin
            op_reg <= op;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= a_in[i][W-1] ^ ((op == OP_HOMO) && a_in[3][W-1]);
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/vaq_exec.sv =====
// Back end: multiply stage, sum stage and saturating output stage.
module vaq_exec
    import vaq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    input  logic [item_w(COMP_WIDTH)-1:0]                       in_item,
    output logic                                                in_pop,
    output logic                                                iter_start,
    output logic [OP_W-1:0]                                     iter_op,
    output logic signed [COMP_WIDTH-1:0]                        iter_a [4],
    output logic signed [wide_w(COMP_WIDTH, FRAC_BITS)-1:0]     iter_sum,
    input  logic                                                iter_valid,
    input  logic signed [wide_w(COMP_WIDTH, FRAC_BITS)-1:0]     iter_res [5],
    output logic                                                done,
    output logic signed [COMP_WIDTH-1:0]                        rx,
    output logic signed [COMP_WIDTH-1:0]                        ry,
    output logic signed [COMP_WIDTH-1:0]                        rz,
    output logic signed [COMP_WIDTH-1:0]                        rw,
    output logic signed [COMP_WIDTH-1:0]                        scalar_out,
    output logic [STATUS_W-1:0]                                 status
);

    localparam int W  = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = oper_w(COMP_WIDTH, FRAC_BITS);
    localparam int PW = 2 * MW;
    localparam int LW = W + 1;
    localparam int WV = wide_w(COMP_WIDTH, FRAC_BITS);

    localparam logic signed [MW-1:0] ONE_M  = MW'(1) << F;
    localparam logic signed [WV-1:0] CMAX_V = (WV'(1) << (W - 1)) - WV'(1);
    localparam logic signed [WV-1:0] CMIN_V = -CMAX_V - WV'(1);

    // unpacked queue beat
    logic [OP_W-1:0]       in_op;
    logic [CLS_W-1:0]      in_cls;
    logic [MASK_W-1:0]     in_mask;
    logic signed [W-1:0]   in_sc;
    logic signed [W-1:0]   in_a [4];
    logic signed [W-1:0]   in_b [4];
    logic signed [MW-1:0]  in_d [3];
    logic signed [MW-1:0]  om_sc;
    logic signed [MW-1:0]  ma [6];
    logic signed [MW-1:0]  mb [6];
    logic signed [LW-1:0]  lin [4];

    logic                  pending_reg;
    logic                  pending_next;

    // stage 1 registers
    logic                  s1_valid_reg;
    logic [OP_W-1:0]       s1_op_reg;
    logic [CLS_W-1:0]      s1_cls_reg;
    logic [MASK_W-1:0]     s1_mask_reg;
    logic signed [PW-1:0]  s1_p_reg [6];
    logic signed [LW-1:0]  s1_lin_reg [4];
    logic signed [W-1:0]   s1_a_reg [4];

    // stage 2 registers
    logic                  s2_valid_reg;
    logic                  s2_dz_reg;
    logic [4:0]            s2_sh_reg;
    logic signed [WV-1:0]  s2_v_reg [5];
    logic signed [WV-1:0]  v2 [5];
    logic [4:0]            sh2;
    logic signed [WV-1:0]  sum3;

    // output stage
    logic signed [WV-1:0]  sel_v [5];
    logic [4:0]            sel_sh;
    logic                  sel_dz;
    logic signed [WV-1:0]  shv [5];
    logic signed [W-1:0]   fld [5];
    logic [4:0]            fsat;
    logic                  done_reg;
    logic signed [W-1:0]   out_reg [5];
    logic signed [W-1:0]   out_next [5];
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    // unpack the beat at the queue head
    always_comb
    begin
        in_op   = in_item[OP_LSB +: OP_W];
        in_cls  = in_item[CLS_LSB +: CLS_W];
        in_mask = in_item[MASK_LSB +: MASK_W];
        in_sc   = in_item[DATA_LSB +: W];
        for (int i = 0; i < 4; i++)
        begin
            in_a[i] = in_item[DATA_LSB + (i + 1) * W +: W];
            in_b[i] = in_item[DATA_LSB + (i + 5) * W +: W];
        end
        for (int i = 0; i < 3; i++)
        begin
            in_d[i] = MW'(in_a[i]) - MW'(in_b[i]);
        end
        om_sc = ONE_M - MW'(in_sc);
    end

    // issue only when no root or divide is in flight, which keeps order
    assign in_pop = in_valid && !pending_reg;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_pop && in_cls == CLS_ITER)
        begin
            pending_next = 1'b1;
        end
        else if (iter_valid)
        begin
            pending_next = 1'b0;
        end
    end

    // select multiplier operands and the linear results
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            lin[i] = '0;
        end
        unique case (in_op) inside
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lin[i] = LW'(in_a[i]) + LW'(in_b[i]);
                end
            end
            OP_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lin[i] = LW'(in_a[i]) - LW'(in_b[i]);
                end
            end
            OP_INV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lin[i] = -LW'(in_a[i]);
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ma[i]  = MW'(in_a[i]);
                    mb[i]  = MW'(in_sc);
                    lin[i] = LW'(in_a[i]);
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = MW'(in_a[i]);
                    mb[i] = MW'(in_b[i]);
                end
            end
            OP_SQLEN, OP_LEN, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = MW'(in_a[i]);
                    mb[i] = MW'(in_a[i]);
                end
            end
            OP_SQDIST, OP_DIST:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = in_d[i];
                    mb[i] = in_d[i];
                end
            end
            OP_CROSS:
            begin
                ma[0] = MW'(in_a[1]); mb[0] = MW'(in_b[2]);
                ma[1] = MW'(in_a[2]); mb[1] = MW'(in_b[1]);
                ma[2] = MW'(in_a[2]); mb[2] = MW'(in_b[0]);
                ma[3] = MW'(in_a[0]); mb[3] = MW'(in_b[2]);
                ma[4] = MW'(in_a[0]); mb[4] = MW'(in_b[1]);
                ma[5] = MW'(in_a[1]); mb[5] = MW'(in_b[0]);
            end
            OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[2*i]   = MW'(in_a[i]);
                    mb[2*i]   = om_sc;
                    ma[2*i+1] = MW'(in_b[i]);
                    mb[2*i+1] = MW'(in_sc);
                end
            end
            default:
            begin
                lin[0] = '0;
            end
        endcase
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            s1_op_reg   <= in_op;
            s1_cls_reg  <= in_cls;
            s1_mask_reg <= in_mask;
            for (int i = 0; i < 6; i++)
            begin
                s1_p_reg[i] <= ma[i] * mb[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                s1_lin_reg[i] <= lin[i];
                s1_a_reg[i]   <= in_a[i];
            end
        end
    end

    // stage 2: combine products per operation
    assign sum3 = WV'(s1_p_reg[0]) + WV'(s1_p_reg[1]) + WV'(s1_p_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            v2[i] = '0;
        end
        sh2 = '0;
        unique case (s1_op_reg) inside
            OP_ADD, OP_SUB, OP_INV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    v2[i] = WV'(s1_lin_reg[i]);
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    v2[i]  = s1_mask_reg[i] ? WV'(s1_p_reg[i]) : WV'(s1_lin_reg[i]);
                    sh2[i] = s1_mask_reg[i];
                end
            end
            OP_DOT, OP_SQLEN, OP_SQDIST:
            begin
                v2[4]  = sum3;
                sh2[4] = 1'b1;
            end
            OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v2[i]  = WV'(s1_p_reg[2*i]) - WV'(s1_p_reg[2*i+1]);
                    sh2[i] = 1'b1;
                end
            end
            OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v2[i]  = WV'(s1_p_reg[2*i]) + WV'(s1_p_reg[2*i+1]);
                    sh2[i] = 1'b1;
                end
            end
            default:
            begin
                sh2 = '0;
            end
        endcase
    end

    // hand roots and divides to the iterative unit
    assign iter_start = s1_valid_reg && (s1_cls_reg == CLS_ITER);
    assign iter_op    = s1_op_reg;
    assign iter_a     = s1_a_reg;
    assign iter_sum   = sum3;

    always_ff @(posedge clk)
    begin
        s2_dz_reg <= (s1_cls_reg == CLS_DZ);
        s2_sh_reg <= sh2;
        for (int i = 0; i < 5; i++)
        begin
            s2_v_reg[i] <= v2[i];
        end
    end

    // output stage: shift out the fraction, saturate and flag
    always_comb
    begin
        sel_sh = iter_valid ? 5'b0 : s2_sh_reg;
        sel_dz = iter_valid ? 1'b0 : s2_dz_reg;
        for (int i = 0; i < 5; i++)
        begin
            sel_v[i] = iter_valid ? iter_res[i] : s2_v_reg[i];
            shv[i]   = sel_sh[i] ? (sel_v[i] >>> F) : sel_v[i];
            fsat[i]  = 1'b0;
            if (shv[i] > CMAX_V)
            begin
                fld[i]  = CMAX_V[W-1:0];
                fsat[i] = 1'b1;
            end
            else if (shv[i] < CMIN_V)
            begin
                fld[i]  = CMIN_V[W-1:0];
                fsat[i] = 1'b1;
            end
            else
            begin
                fld[i] = shv[i][W-1:0];
            end
            out_next[i] = sel_dz ? '0 : fld[i];
        end
        if (sel_dz)
        begin
            status_next = STAT_DZ;
        end
        else if (fsat != '0)
        begin
            status_next = STAT_SAT;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            out_reg[i] <= out_next[i];
        end
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            s1_valid_reg <= in_pop;
            s2_valid_reg <= s1_valid_reg && (s1_cls_reg != CLS_ITER);
            done_reg     <= iter_valid || s2_valid_reg;
        end
    end

    assign done       = done_reg;
    assign rx         = out_reg[0];
    assign ry         = out_reg[1];
    assign rz         = out_reg[2];
    assign rw         = out_reg[3];
    assign scalar_out = out_reg[4];
    assign status     = status_reg;

    // an iterative result never meets a pipelined one at the output stage
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(iter_valid && s2_valid_reg))
        else $error("iterative and pipelined results collide");

    // an iterative result only comes back for an issued iterative beat
    a_iter_expected: assert property (@(posedge clk) disable iff (!rst_n)
        iter_valid |-> pending_reg)
        else $error("unexpected iterative result");

    // issuing an iterative beat blocks further issue
    a_iter_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_pop && in_cls == CLS_ITER) |=> (pending_reg && !in_pop))
        else $error("issue not blocked behind iterative beat");

endmodule

// ===== src/vector_alu_q16_top.sv =====
// Top level of the fixed-point four-component vector ALU.
//
// Commands enter on start with action, ax..bw, scalar_in and comp_mask; a
// beat is taken at a rising edge where start is high and busy is low. Each
// beat yields one result on rx, ry, rz, rw, scalar_out and status, valid for
// exactly one cycle while done is high; the receiver cannot stall it.
// Add, sub, scale, invert, dot, cross, lerp, squared length and squared
// distance run through a three-stage multiply/sum/saturate pipeline, which
// takes one beat per cycle while no root or divide is in flight.
// Length and distance go through a bit-serial square root of COMP_WIDTH+1
// steps; homogenise through three parallel restoring dividers of
// COMP_WIDTH+FRAC_BITS steps; normalise through both.
// While one of these runs, later beats wait in a four-entry queue so results
// leave in order; busy rises when the queue and the input register are full.
// A zero length or zero w resolves at the front end and takes the fast path.
// Reset empties the queue and pipeline and returns the iterative unit to idle.
module vector_alu_q16_top
    import vaq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [OP_W-1:0]               action,
    input  logic signed [COMP_WIDTH-1:0]  ax,
    input  logic signed [COMP_WIDTH-1:0]  ay,
    input  logic signed [COMP_WIDTH-1:0]  az,
    input  logic signed [COMP_WIDTH-1:0]  aw,
    input  logic signed [COMP_WIDTH-1:0]  bx,
    input  logic signed [COMP_WIDTH-1:0]  by,
    input  logic signed [COMP_WIDTH-1:0]  bz,
    input  logic signed [COMP_WIDTH-1:0]  bw,
    input  logic signed [COMP_WIDTH-1:0]  scalar_in,
    input  logic [MASK_W-1:0]             comp_mask,
    output logic                          done,
    output logic signed [COMP_WIDTH-1:0]  rx,
    output logic signed [COMP_WIDTH-1:0]  ry,
    output logic signed [COMP_WIDTH-1:0]  rz,
    output logic signed [COMP_WIDTH-1:0]  rw,
    output logic signed [COMP_WIDTH-1:0]  scalar_out,
    output logic [STATUS_W-1:0]           status
);

    localparam int IW = item_w(COMP_WIDTH);
    localparam int WV = wide_w(COMP_WIDTH, FRAC_BITS);

    logic                         fr_valid;
    logic [IW-1:0]                fr_item;
    logic                         q_ready;
    logic                         q_valid;
    logic [IW-1:0]                q_item;
    logic                         q_pop;
    logic                         it_start;
    logic [OP_W-1:0]              it_op;
    logic signed [COMP_WIDTH-1:0] it_a [4];
    logic signed [WV-1:0]         it_sum;
    logic                         it_valid;
    logic signed [WV-1:0]         it_res [5];

    vaq_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .ax         (ax),
        .ay         (ay),
        .az         (az),
        .aw         (aw),
        .bx         (bx),
        .by         (by),
        .bz         (bz),
        .bw         (bw),
        .scalar_in  (scalar_in),
        .comp_mask  (comp_mask),
        .item_valid (fr_valid),
        .item       (fr_item),
        .item_ready (q_ready)
    );

    vaq_fifo #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fr_valid),
        .wr_data  (fr_item),
        .wr_ready (q_ready),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_item)
    );

    vaq_exec #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .in_pop     (q_pop),
        .iter_start (it_start),
        .iter_op    (it_op),
        .iter_a     (it_a),
        .iter_sum   (it_sum),
        .iter_valid (it_valid),
        .iter_res   (it_res),
        .done       (done),
        .rx         (rx),
        .ry         (ry),
        .rz         (rz),
        .rw         (rw),
        .scalar_out (scalar_out),
        .status     (status)
    );

    vaq_iter #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (it_start),
        .op        (it_op),
        .a_in      (it_a),
        .sum       (it_sum),
        .res_valid (it_valid),
        .res       (it_res)
    );

endmodule
